// File: rtl/core/ksmc_pkg.sv
// Package with sizes, codes and link types of the keyed stack.
`default_nettype none
package ksmc_pkg;

   // Store size and field widths.
   localparam int DEPTH  = 8;
   localparam int KEY_W  = 32;
   localparam int MOVE_W = 8;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STAT_W = 3;

   localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

   // Request operations.
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

   // Control broadcast to every cell for the request being taken.
   typedef struct packed {
      logic                    push;
      logic                    remove;
      logic signed [KEY_W-1:0] key;
      logic [CNT_W-1:0]        count;
   } ctrl_type;

   // Search link that runs from the top cell down to the bottom cell.
   typedef struct packed {
      logic                    hit;
      logic signed [KEY_W-1:0] key;
      logic [MOVE_W-1:0]       moves;
   } link_type;

   // Entry data handed down one slot when the gap closes.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [MOVE_W-1:0]       moves;
   } entry_type;

endpackage
`default_nettype wire

// File: rtl/core/keyed_stack_with_move_counts.sv
// Top level of the keyed stack with move counts.
`default_nettype none
// Each request is taken as soon as it is given: busy never rises, and a request may be given
// in every cycle. Its result appears on the rsp_ ports in the cycle after the
// request, for exactly one cycle, marked by rsp_strobe; the receiver cannot
// stall, so it must take every result when it is shown. The search, the
// counter updates and the closing of the gap all happen in one pass down the
// row of DEPTH slot cells.
module keyed_stack_with_move_counts (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_func,
   input  wire logic signed [ksmc_pkg::KEY_W-1:0]   req_key,
   output logic                                     rsp_strobe,
   output logic [ksmc_pkg::STAT_W-1:0]              rsp_status,
   output logic signed [ksmc_pkg::KEY_W-1:0]        rsp_key_out,
   output logic [ksmc_pkg::MOVE_W-1:0]              rsp_moves
);

   logic                              fire;
   logic [ksmc_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              strobe_ff;
   logic [ksmc_pkg::STAT_W-1:0]       status_ff, status_in;
   logic signed [ksmc_pkg::KEY_W-1:0] key_out_ff, key_out_in;
   logic [ksmc_pkg::MOVE_W-1:0]       moves_ff, moves_in;
   logic                              full;
   logic                              empty;
   ksmc_pkg::ctrl_type                ctrl;
   ksmc_pkg::link_type                links   [ksmc_pkg::DEPTH:0];
   ksmc_pkg::entry_type               entries [ksmc_pkg::DEPTH:0];

   assign busy  = 1'b0;
   assign fire  = start && !busy;
   assign full  = count_ff == ksmc_pkg::CNT_W'(ksmc_pkg::DEPTH);
   assign empty = count_ff == '0;

   // Request control broadcast to the cells.
   always_comb begin
      ctrl.push   = fire && (req_func == ksmc_pkg::FUNC_ADD);
      ctrl.remove = fire && (req_func == ksmc_pkg::FUNC_REMOVE);
      ctrl.key    = req_key;
      ctrl.count  = count_ff;
   end

   // Nothing comes down from above the top slot.
   assign links[ksmc_pkg::DEPTH]   = '0;
   assign entries[ksmc_pkg::DEPTH] = '0;

   // Row of slot cells, top slot at the high index.
   for (genvar i = 0; i < ksmc_pkg::DEPTH; i++) begin : g_cell
      ksmc_cell u_cell (
         .clock    (clock),
         .idx      (ksmc_pkg::IDX_W'(i)),
         .ctrl     (ctrl),
         .found    (links[0].hit),
         .link_up  (links[i+1]),
         .link_dn  (links[i]),
         .entry_up (entries[i+1]),
         .entry_dn (entries[i])
      );
   end

   // Result and count for the request.
   always_comb begin
      count_in   = count_ff;
      status_in  = ksmc_pkg::ST_ADDED;
      key_out_in = req_key;
      moves_in   = '0;
      if (req_func == ksmc_pkg::FUNC_ADD) begin
         if (full) begin
            status_in = ksmc_pkg::ST_FULL;
         end else begin
            status_in = ksmc_pkg::ST_ADDED;
            count_in  = count_ff + 1'b1;
         end
      end else if (empty) begin
         status_in = ksmc_pkg::ST_EMPTY;
      end else if (links[0].hit) begin
         status_in  = ksmc_pkg::ST_REMOVED;
         key_out_in = links[0].key;
         moves_in   = links[0].moves;
         count_in   = count_ff - 1'b1;
      end else begin
         status_in = ksmc_pkg::ST_NOTFOUND;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fire;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff  <= status_in;
         key_out_ff <= key_out_in;
         moves_ff   <= moves_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_status  = status_ff;
   assign rsp_key_out = key_out_ff;
   assign rsp_moves   = moves_ff;

endmodule
`default_nettype wire

// File: rtl/core/ksmc_cell.sv
// One stack slot: holds a key and a move counter and talks to its neighbors.
`default_nettype none
module ksmc_cell (
   input  wire logic                  clock,
   input  wire logic [ksmc_pkg::IDX_W-1:0] idx,
   input  wire ksmc_pkg::ctrl_type    ctrl,
   input  wire logic                  found,
   input  wire ksmc_pkg::link_type    link_up,
   output ksmc_pkg::link_type         link_dn,
   input  wire ksmc_pkg::entry_type   entry_up,
   output ksmc_pkg::entry_type        entry_dn
);

   logic signed [ksmc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [ksmc_pkg::MOVE_W-1:0]       moves_ff, moves_in;
   logic                              occupied;
   logic                              match;
   logic                              first;
   logic                              passed;
   logic [ksmc_pkg::MOVE_W-1:0]       moves_kept;

   // The slot holds an entry when it lies below the count.
   assign occupied = ksmc_pkg::CNT_W'(idx) < ctrl.count;
   assign match    = occupied && (key_ff == ctrl.key);
   assign first    = match && !link_up.hit;
   assign passed   = occupied && !link_up.hit && !match;

   // Entries passed over by the search have their counter raised, saturating.
   always_comb begin
      moves_kept = moves_ff;
      if (passed && (moves_ff != ksmc_pkg::MOVE_MAX)) begin
         moves_kept = moves_ff + 1'b1;
      end
   end

   // Search result travels downward; the first hit from the top wins.
   always_comb begin
      link_dn.hit   = link_up.hit || first;
      link_dn.key   = first ? key_ff : link_up.key;
      link_dn.moves = first ? moves_ff : link_up.moves;
   end

   // The entry offered to the slot below when the gap closes.
   assign entry_dn = '{key: key_ff, moves: moves_kept};

   // Next slot contents. On a hit, the matching slot and every slot above it
   // take the entry from the slot above; slots below the match stay put.
   always_comb begin
      key_in   = key_ff;
      moves_in = moves_ff;
      if (ctrl.push && (ksmc_pkg::CNT_W'(idx) == ctrl.count)) begin
         key_in   = ctrl.key;
         moves_in = '0;
      end else if (ctrl.remove) begin
         if (found && !link_up.hit) begin
            key_in   = entry_up.key;
            moves_in = entry_up.moves;
         end else begin
            moves_in = moves_kept;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      moves_ff <= moves_in;
   end

endmodule
`default_nettype wire

// File: test/keyed_stack_with_move_counts_tb.sv
// Self-checking testbench for the keyed stack with move counts.
`default_nettype none
module keyed_stack_with_move_counts_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int SOAK_MISSES  = 260;
   localparam int POOL_SIZE    = 12;

   // One expected result of the block.
   typedef struct packed {
      logic [ksmc_pkg::STAT_W-1:0]       status;
      logic signed [ksmc_pkg::KEY_W-1:0] key;
      logic [ksmc_pkg::MOVE_W-1:0]       moves;
   } rsp_rec_type;

   // Mirror of the stack: it applies each accepted request to its own copy of
   // the store and keeps the results that the block still owes.
   class stack_mirror;
      logic signed [ksmc_pkg::KEY_W-1:0] slot_key [ksmc_pkg::DEPTH];
      logic [ksmc_pkg::MOVE_W-1:0]       slot_moves [ksmc_pkg::DEPTH];
      int                                held;
      rsp_rec_type                       due_rsps [$];
      int unsigned                       errors;
      int unsigned                       checked;
      int unsigned                       tally [5];
      int unsigned                       top_moves;

      function new();
         held      = 0;
         errors    = 0;
         checked   = 0;
         top_moves = 0;
         foreach (tally[s]) tally[s] = 0;
         foreach (slot_key[s]) begin
            slot_key[s]   = '0;
            slot_moves[s] = '0;
         end
      endfunction

      function int pending();
         return due_rsps.size();
      endfunction

      // Work out the result of one request and update the mirrored store.
      function void apply_request(logic func, logic signed [ksmc_pkg::KEY_W-1:0] key);
         rsp_rec_type r;
         int          i;
         int          at;
         bit          found;
         r.status = ksmc_pkg::ST_ADDED;
         r.key    = key;
         r.moves  = '0;
         found    = 1'b0;
         at       = 0;
         if (func == ksmc_pkg::FUNC_ADD) begin
            if (held >= ksmc_pkg::DEPTH) begin
               r.status = ksmc_pkg::ST_FULL;
            end else begin
               slot_key[held]   = key;
               slot_moves[held] = '0;
               held++;
            end
         end else if (held == 0) begin
            r.status = ksmc_pkg::ST_EMPTY;
         end else begin
            // Search from the top; every entry passed over gains one move, saturating.
            i = held - 1;
            while (i >= 0 && !found) begin
               if (slot_key[i] == key) begin
                  found = 1'b1;
                  at    = i;
               end else begin
                  if (slot_moves[i] != ksmc_pkg::MOVE_MAX)
                     slot_moves[i] = slot_moves[i] + 1'b1;
                  i--;
               end
            end
            if (!found) begin
               r.status = ksmc_pkg::ST_NOTFOUND;
            end else begin
               // Take the match out and let the entries above it slide down.
               r.status = ksmc_pkg::ST_REMOVED;
               r.key    = slot_key[at];
               r.moves  = slot_moves[at];
               for (i = at; i < held - 1; i++) begin
                  slot_key[i]   = slot_key[i + 1];
                  slot_moves[i] = slot_moves[i + 1];
               end
               held--;
            end
         end
         due_rsps.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      // Compare one result from the block with the oldest one owed.
      task check_rsp(logic [ksmc_pkg::STAT_W-1:0] status,
                     logic signed [ksmc_pkg::KEY_W-1:0] key,
                     logic [ksmc_pkg::MOVE_W-1:0] moves);
         rsp_rec_type want;
         if (due_rsps.size() == 0) begin
            report($sformatf("unexpected result: status %0d key %h moves %0d",
                             status, key, moves));
            return;
         end
         want = due_rsps.pop_front();
         checked++;
         if (want.status <= ksmc_pkg::ST_EMPTY) tally[want.status]++;
         if (want.moves > top_moves) top_moves = want.moves;
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (key !== want.key)
            report($sformatf("key_out %h, expected %h", key, want.key));
         if (moves !== want.moves)
            report($sformatf("moves %0d, expected %0d", moves, want.moves));
      endtask
   endclass

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_func;
   logic signed [ksmc_pkg::KEY_W-1:0] req_key;
   logic                              rsp_strobe;
   logic [ksmc_pkg::STAT_W-1:0]       rsp_status;
   logic signed [ksmc_pkg::KEY_W-1:0] rsp_key_out;
   logic [ksmc_pkg::MOVE_W-1:0]       rsp_moves;

   stack_mirror                       mirror;
   int unsigned                       cycles;
   int                                burst_left;
   logic signed [ksmc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   keyed_stack_with_move_counts u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_key    (req_key),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_key_out(rsp_key_out),
      .rsp_moves  (rsp_moves)
   );

   // Clock with a period of 12 time units.
   always #6 clock = ~clock;

   // Note each accepted request and check each result at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) mirror.apply_request(req_func, req_key);
         if (rsp_strobe) mirror.check_rsp(rsp_status, rsp_key_out, rsp_moves);
      end
   end

   // Stop a run that hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results owed", cycles, mirror.pending());
         $display("status: fail");
         $finish;
      end
   end

   // Hold start low with random content on the request ports; n sets how long.
   task automatic idle(int n);
      start    <= 1'b0;
      req_func <= 1'($urandom);
      req_key  <= $urandom;
      repeat (n) @(negedge clock);
   endtask

   // The sender works in bursts of random length with random gaps between.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Offer one request at a falling edge and hold it until it is taken.
   task automatic send_request(logic func, logic signed [ksmc_pkg::KEY_W-1:0] key);
      start    <= 1'b1;
      req_func <= func;
      req_key  <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      pace_sender();
   endtask

   // Pause the sender until every owed result has come back.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (mirror.pending() != 0);
   endtask

   // Fill the stack, push every counter to saturation with searches that
   // cannot hit, then take the entries out in a random order.
   task automatic soak_counters();
      logic signed [ksmc_pkg::KEY_W-1:0] fill [ksmc_pkg::DEPTH];
      logic signed [ksmc_pkg::KEY_W-1:0] swap;
      int                                j;
      for (int i = 0; i < ksmc_pkg::DEPTH; i++) begin
         fill[i] = {1'b0, 27'($urandom), 4'(i)};
         send_request(ksmc_pkg::FUNC_ADD, fill[i]);
      end
      for (int i = 0; i < SOAK_MISSES; i++)
         send_request(ksmc_pkg::FUNC_REMOVE, {1'b1, 31'($urandom)});
      for (int i = ksmc_pkg::DEPTH - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         swap    = fill[i];
         fill[i] = fill[j];
         fill[j] = swap;
      end
      for (int i = 0; i < ksmc_pkg::DEPTH; i++) send_request(ksmc_pkg::FUNC_REMOVE, fill[i]);
   endtask

   // Random traffic: keys mostly from a small pool so that searches hit, and
   // the add share changes now and then to reach both full and empty.
   task automatic random_traffic();
      int                                add_pct;
      logic                              func;
      logic signed [ksmc_pkg::KEY_W-1:0] key;
      add_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: add_pct = 25;
               1: add_pct = 50;
               default: add_pct = 80;
            endcase
            if ($urandom_range(0, 4) == 0) drain();
         end
         func = ($urandom_range(0, 99) < add_pct) ? ksmc_pkg::FUNC_ADD
                                                  : ksmc_pkg::FUNC_REMOVE;
         if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = $urandom;
         send_request(func, key);
      end
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_func   = ksmc_pkg::FUNC_ADD;
      req_key    = '0;
      cycles     = 0;
      burst_left = 0;
      mirror     = new();
      key_pool[0] = 32'sh7FFF_FFFF;
      key_pool[1] = 32'sh8000_0000;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = 32'shFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // Hold reset, then release it at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty, the key extremes, full, a miss, removes from
      // the bottom, the top and the middle, and duplicate keys.
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh8000_0000);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh7FFF_FFFF);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh8000_0000);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh0000_0000);
      send_request(ksmc_pkg::FUNC_ADD, 32'shFFFF_FFFF);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh0000_0001);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh5555_5555);
      send_request(ksmc_pkg::FUNC_ADD, 32'shAAAA_AAAA);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh1234_5678);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh0000_0007);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh0000_03E7);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh7FFF_FFFF);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh1234_5678);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh0000_0000);
      send_request(ksmc_pkg::FUNC_ADD, 32'sh5555_5555);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh5555_5555);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh5555_5555);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh8000_0000);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'shFFFF_FFFF);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh0000_0001);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'shAAAA_AAAA);
      send_request(ksmc_pkg::FUNC_REMOVE, 32'sh0000_0000);
      drain();

      soak_counters();
      drain();

      random_traffic();

      // Let the last results come back before the summary is printed.
      drain();
      repeat (4) @(negedge clock);

      $display("%0d requests checked: %0d added, %0d full, %0d removed, %0d missed, %0d empty",
               mirror.checked, mirror.tally[ksmc_pkg::ST_ADDED],
               mirror.tally[ksmc_pkg::ST_FULL], mirror.tally[ksmc_pkg::ST_REMOVED],
               mirror.tally[ksmc_pkg::ST_NOTFOUND], mirror.tally[ksmc_pkg::ST_EMPTY]);
      $display("highest move count returned: %0d; mismatches: %0d",
               mirror.top_moves, mirror.errors);
      if (mirror.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
